@@ rtl/rbld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbld_pkg: shared types and constants of the repeated block loop detector
// Holds the key width, register indexes, defaults and the result item type.
// ----------------------------------------------------------------------------
package rbld_pkg;

   localparam int KEY_W             = 33;
   localparam int ADDR_W            = 32;
   localparam int LEN_W             = 5;
   localparam int CAP_W             = 8;
   localparam int DEF_WINDOW_DEPTH  = 32;
   localparam logic [CAP_W-1:0] DEF_ITER_CAP = 8'd8;

   // register indexes of the csr port
   localparam logic CSR_DETECT_ENABLE = 1'b0;
   localparam logic CSR_ITERATION_CAP = 1'b1;

   typedef struct packed {
      logic             enable;
      logic [CAP_W-1:0] cap;
   } rbld_cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              thumb;
      logic [LEN_W-1:0]  length;
      logic              last;
   } rbld_result_type;

endpackage

@@ rtl/rbld_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbld_front: window of recent keys, candidate loop tracking, body emission
// Accepts one block per cycle while scanning; on a commit it walks the frozen
// window and pushes the loop body into the result queue.
// ----------------------------------------------------------------------------
module rbld_front #(
   parameter int WINDOW_DEPTH = rbld_pkg::DEF_WINDOW_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rbld_pkg::rbld_cfg_type         cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rbld_pkg::ADDR_W-1:0]    req_addr,
   input  logic                           req_thumb,
   output logic                           push_valid,
   input  logic                           push_ready,
   output rbld_pkg::rbld_result_type      push_data
);
   import rbld_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam logic STATE_SCAN = 1'b0;
   localparam logic STATE_EMIT = 1'b1;

   logic             state_ff, state_in;
   logic [KEY_W-1:0] win_ff [WINDOW_DEPTH];
   logic [KEY_W-1:0] win_in [WINDOW_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] base_ff, base_in;
   logic [IDX_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] exp_ff, exp_in;
   logic [CAP_W-1:0] iter_ff, iter_in;
   logic [IDX_W-1:0] emit_ff, emit_in;
   logic [KEY_W-1:0] pend_ff, pend_in;

   logic [KEY_W-1:0] key;
   logic [IDX_W-1:0] rd_idx;
   logic [KEY_W-1:0] rd_key;
   logic             full;
   logic [KEY_W-1:0] app_win [WINDOW_DEPTH];
   logic [CNT_W-1:0] app_count;
   logic             found;
   logic [IDX_W-1:0] found_idx;
   logic [IDX_W-1:0] new_len;
   logic [IDX_W-1:0] exp_inc;
   logic [CAP_W-1:0] iter_inc;
   logic             accept;
   logic             emit_last;

   assign key       = {req_addr, req_thumb};
   assign req_ready = (state_ff == STATE_SCAN);
   assign accept    = req_valid & req_ready;

   // one shared read of the window: expected entry or body entry being emitted
   assign rd_idx = base_ff + ((state_ff == STATE_EMIT) ? emit_ff : exp_ff);
   assign rd_key = win_ff[rd_idx];

   // window after appending the key, oldest entry dropped when full
   assign full = (count_ff == CNT_W'(WINDOW_DEPTH));
   always_comb begin
      for (int p = 0; p < WINDOW_DEPTH; p++) begin
         if (full) begin
            app_win[p] = (p == WINDOW_DEPTH - 1) ? key : win_ff[(p + 1) % WINDOW_DEPTH];
         end else begin
            app_win[p] = (count_ff == CNT_W'(p)) ? key : win_ff[p];
         end
      end
   end
   assign app_count = full ? count_ff : count_ff + CNT_W'(1);

   // oldest earlier entry equal to the key
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int p = WINDOW_DEPTH - 1; p >= 0; p--) begin
         if ((CNT_W'(p) + CNT_W'(1) < app_count) && (app_win[p] == key)) begin
            found     = 1'b1;
            found_idx = IDX_W'(p);
         end
      end
   end
   assign new_len = IDX_W'(app_count - CNT_W'(1) - CNT_W'(found_idx));

   assign exp_inc  = exp_ff + IDX_W'(1);
   assign iter_inc = iter_ff + CAP_W'(1);

   // body emission into the queue
   assign emit_last        = (emit_ff == len_ff - IDX_W'(1));
   assign push_valid       = (state_ff == STATE_EMIT);
   assign push_data.addr   = rd_key[KEY_W-1:1];
   assign push_data.thumb  = rd_key[0];
   assign push_data.length = LEN_W'(len_ff);
   assign push_data.last   = emit_last;

   // next state
   always_comb begin
      state_in = state_ff;
      win_in   = win_ff;
      count_in = count_ff;
      base_in  = base_ff;
      len_in   = len_ff;
      exp_in   = exp_ff;
      iter_in  = iter_ff;
      emit_in  = emit_ff;
      pend_in  = pend_ff;
      if (state_ff == STATE_EMIT) begin
         if (push_ready) begin
            emit_in = emit_ff + IDX_W'(1);
            if (emit_last) begin
               state_in  = STATE_SCAN;
               win_in[0] = pend_ff;
               count_in  = CNT_W'(1);
               len_in    = '0;
               exp_in    = '0;
               iter_in   = '0;
            end
         end
      end else if (accept && cfg.enable) begin
         if (len_ff != '0) begin
            if (key != rd_key) begin
               win_in[0] = key;
               count_in  = CNT_W'(1);
               len_in    = '0;
               exp_in    = '0;
               iter_in   = '0;
            end else if (exp_inc == len_ff) begin
               exp_in  = '0;
               iter_in = iter_inc;
               if (iter_inc >= cfg.cap) begin
                  state_in = STATE_EMIT;
                  emit_in  = '0;
                  pend_in  = key;
               end
            end else begin
               exp_in = exp_inc;
            end
         end else begin
            win_in   = app_win;
            count_in = app_count;
            if (found) begin
               base_in = found_idx;
               len_in  = new_len;
               exp_in  = (new_len == IDX_W'(1)) ? '0 : IDX_W'(1);
               iter_in = CAP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_SCAN;
         count_ff <= '0;
         len_ff   <= '0;
         exp_ff   <= '0;
         iter_ff  <= '0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         exp_ff   <= exp_in;
         iter_ff  <= iter_in;
         emit_ff  <= emit_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      base_ff <= base_in;
      pend_ff <= pend_in;
   end

   // expected index stays inside an open body
   a_exp_in_body: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) |-> (exp_ff < len_ff))
      else $error("expected index outside loop body");

   // an open body lies inside the filled part of the window
   a_body_in_window: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) |-> (CNT_W'(base_ff) + CNT_W'(len_ff) < count_ff))
      else $error("loop body exceeds window");

   // the final body item restarts the window with the pending key
   a_restart_after_emit: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_ready && push_data.last) |=>
         (state_ff == STATE_SCAN && len_ff == '0 && count_ff == CNT_W'(1)))
      else $error("window not restarted after commit");

endmodule

@@ rtl/rbld_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbld_queue: two-entry result queue
// Decouples body emission from the result channel so either side may stall.
// ----------------------------------------------------------------------------
module rbld_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  rbld_pkg::rbld_result_type  push_data,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output rbld_pkg::rbld_result_type  pop_data
);
   import rbld_pkg::*;

   rbld_result_type mem_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   logic            push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/repeated_block_loop_detector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeated_block_loop_detector_unit: loop detector over executed basic blocks
// Finds a repeating run of blocks and reports its body after enough laps.
// ----------------------------------------------------------------------------
// Each block start (address plus Thumb flag) is taken while no body is being
// reported; every window cell compares against the new key in parallel.
// When the iteration cap is reached the body is read out of the frozen window
// one block per cycle, while the two-entry result queue has room, so after a
// commit req_tready stays low until the last body block has been pushed.
// Writes on the csr port take effect at the next clock edge.
module repeated_block_loop_detector_unit #(
   parameter int WINDOW_DEPTH = rbld_pkg::DEF_WINDOW_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // block_address
   input  logic        req_tuser,   // thumb_mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // loop_block_address, loop_length, zero pad
   output logic        rsp_tuser,   // loop_block_thumb
   output logic        rsp_tlast,   // last_of_loop
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   import rbld_pkg::*;

   rbld_cfg_type    cfg_ff, cfg_in;
   logic            push_valid, push_ready;
   rbld_result_type push_data, pop_data;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DETECT_ENABLE: cfg_in.enable = csr_wdata[0];
            CSR_ITERATION_CAP: cfg_in.cap    = csr_wdata;
            default:           cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable <= 1'b0;
         cfg_ff.cap    <= DEF_ITER_CAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbld_front #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_addr   (req_tdata),
      .req_thumb  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rbld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (pop_data)
   );

   // result packing
   assign rsp_tdata = {3'b000, pop_data.length, pop_data.addr};
   assign rsp_tuser = pop_data.thumb;
   assign rsp_tlast = pop_data.last;

endmodule

@@ tb/tb_repeated_block_loop_detector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_repeated_block_loop_detector_unit: self-checking bench for the detector
// Streams block starts (directed loops, random loops, broken loops, noise)
// under random gaps and stalls, predicts the emitted loop bodies in a
// scoreboard and checks every result transaction field by field.
// ----------------------------------------------------------------------------
module tb_repeated_block_loop_detector_unit;
   import rbld_pkg::*;

   localparam int CLK_HALF = 6;
   localparam int SETTLE   = 80;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic        csr_index;
   logic [7:0]  csr_wdata;

   // send and receive sides run without gaps while set
   bit burst;
   // request for one long receiver hold-off
   bit long_hold;

   repeated_block_loop_detector_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // loop body predictor plus queue of pending loop body blocks
   class loop_scoreboard;
      logic [KEY_W-1:0] window_q[$];
      logic [KEY_W-1:0] body_q[$];
      int unsigned      exp_idx;
      logic [CAP_W-1:0] laps;
      logic             enable;
      logic [CAP_W-1:0] cap;
      rbld_result_type  body_out_q[$];
      int               errors;

      function new();
         enable = 1'b0;
         cap    = DEF_ITER_CAP;
         exp_idx = 0;
         laps   = '0;
         errors = 0;
      endfunction

      function void report(string msg);
         $display("ERROR @%0t: %s", $realtime, msg);
         errors++;
      endfunction

      function void restart(logic [KEY_W-1:0] key);
         body_q.delete();
         exp_idx = 0;
         laps    = '0;
         window_q.delete();
         window_q = {window_q, key};
      endfunction

      // accepted block start transaction
      function void note_block(logic [ADDR_W-1:0] addr, logic thumb);
         logic [KEY_W-1:0] key;
         rbld_result_type  r;
         int unsigned      n;
         key = {addr, thumb};
         if (!enable) return;
         // candidate open: follow the body
         if (body_q.size() != 0) begin
            if (key != body_q[exp_idx]) begin
               restart(key);
               return;
            end
            exp_idx++;
            if (exp_idx >= body_q.size()) begin
               exp_idx = 0;
               laps = laps + 1'b1;
               if (laps >= cap) begin
                  n = body_q.size();
                  for (int i = 0; i < n; i++) begin
                     r.addr   = body_q[i][KEY_W-1:1];
                     r.thumb  = body_q[i][0];
                     r.length = LEN_W'(n);
                     r.last   = (i == n - 1);
                     body_out_q = {body_out_q, r};
                  end
                  restart(key);
               end
            end
            return;
         end
         // window search, oldest match first
         if (window_q.size() >= DEF_WINDOW_DEPTH) void'(window_q.pop_front());
         window_q = {window_q, key};
         n = window_q.size();
         for (int i = 0; i + 1 < n; i++) begin
            if (window_q[i] == key) begin
               body_q = window_q[i:n-2];
               exp_idx = 1 % body_q.size();
               laps = 1;
               return;
            end
         end
      endfunction

      function void check_result(logic [ADDR_W-1:0] addr, logic thumb,
                                 logic [LEN_W-1:0] length, logic last);
         rbld_result_type e;
         if (body_out_q.size() == 0) begin
            report($sformatf("unexpected result addr=%h", addr));
            return;
         end
         e = body_out_q.pop_front();
         if (addr !== e.addr)
            report($sformatf("addr got %h exp %h", addr, e.addr));
         if (thumb !== e.thumb)
            report($sformatf("thumb got %b exp %b", thumb, e.thumb));
         if (length !== e.length)
            report($sformatf("length got %0d exp %0d", length, e.length));
         if (last !== e.last)
            report($sformatf("last got %b exp %b", last, e.last));
      endfunction
   endclass

   loop_scoreboard sb;

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // run limit
   initial begin
      #30_000_000;
      $display("tb_repeated_block_loop_detector_unit: FAIL");
      $finish;
   end

   // one block start transaction
   task automatic send_block(logic [ADDR_W-1:0] addr, logic thumb);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      req_tuser  <= thumb;
      do @(posedge clock); while (!req_tready);
      sb.note_block(addr, thumb);
   endtask

   // a body of random blocks, repeated for some laps
   task automatic send_loop(int len, int laps);
      logic [KEY_W-1:0] body[$];
      logic [KEY_W-1:0] k;
      for (int i = 0; i < len; i++) begin
         k    = {$urandom, 1'($urandom)};
         body = {body, k};
      end
      for (int l = 0; l < laps; l++)
         foreach (body[i]) send_block(body[i][KEY_W-1:1], body[i][0]);
      // closing block completes the final lap
      send_block(body[0][KEY_W-1:1], body[0][0]);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.body_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [7:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_DETECT_ENABLE) sb.enable = value[0];
      else sb.cap = value;
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         gap = burst ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata[31:0], rsp_tuser, rsp_tdata[36:32], rsp_tlast);
      end
   end

   // stimulus
   initial begin
      int len;
      sb = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_DETECT_ENABLE;
      csr_wdata  = '0;
      burst      = 1'b0;
      long_hold  = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // detection disabled after reset: repeats are ignored
      repeat (3) send_block(32'h0000_1000, 1'b0);

      // cap of one, extreme addresses, single-block bodies
      csr_write(CSR_DETECT_ENABLE, 8'd1);
      csr_write(CSR_ITERATION_CAP, 8'd1);
      repeat (3) send_block(32'hFFFF_FFFF, 1'b1);
      repeat (3) send_block(32'h0000_0000, 1'b0);
      // same address, other mode is a different key
      send_block(32'h0000_0000, 1'b1);
      send_block(32'h0000_0000, 1'b0);
      // two-block body, then a mismatch mid-body
      send_loop(2, 1);
      send_block(32'h0000_0040, 1'b1);
      send_block(32'h0000_0080, 1'b0);
      send_block(32'h0000_0040, 1'b1);
      send_block(32'h0000_00C0, 1'b0);
      // longest body the window allows
      send_loop(31, 2);

      // random loops at small caps
      for (int ph = 0; ph < 2; ph++) begin
         csr_write(CSR_ITERATION_CAP, 8'(2 + ph));
         for (int n = 0; n < 3; n++) begin
            burst = ($urandom_range(0, 5) == 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 31)
                                              : $urandom_range(1, 4);
            if ($urandom_range(0, 4) == 0) begin
               // noise or broken loop
               repeat ($urandom_range(1, 4)) send_block($urandom, 1'($urandom));
               send_loop(len, 1);
            end else begin
               send_loop(len, 3 + ph);
            end
         end
         burst = 1'b0;
      end

      // cap of zero behaves like a cap of one
      csr_write(CSR_ITERATION_CAP, 8'd0);
      send_loop(2, 2);

      // disabled again
      csr_write(CSR_DETECT_ENABLE, 8'd0);
      repeat (4) send_block(32'h0000_2000, 1'b0);

      // long receiver hold-off while the sender keeps offering loops
      csr_write(CSR_DETECT_ENABLE, 8'd1);
      csr_write(CSR_ITERATION_CAP, 8'd1);
      long_hold = 1'b1;
      burst = 1'b1;
      for (int n = 0; n < 4; n++) send_loop($urandom_range(3, 6), 2);
      burst = 1'b0;

      wait_idle();
      if (sb.errors == 0)
         $display("tb_repeated_block_loop_detector_unit: PASS");
      else
         $display("tb_repeated_block_loop_detector_unit: FAIL");
      $finish;
   end

endmodule

@@ repeated_block_loop_detector_unit.f @@
rtl/rbld_pkg.sv
rtl/rbld_front.sv
rtl/rbld_queue.sv
rtl/repeated_block_loop_detector_unit.sv
tb/tb_repeated_block_loop_detector_unit.sv
